// File: sv/ethernet_header_field_extractor_assert.svh
// ----------------------------------------------------------------------------
// Ethernet header field extractor assertion macros
// Shorthand for the concurrent checks of the extractor, clocked on clk and
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ETHERNET_HEADER_FIELD_EXTRACTOR_ASSERT_SVH
`define ETHERNET_HEADER_FIELD_EXTRACTOR_ASSERT_SVH

// Overlapping implication: the consequent holds in the cycle of the antecedent.
`define EHFE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Non-overlapping implication: the consequent holds in the cycle after the antecedent.
`define EHFE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/ehfe_pkg.sv
// ----------------------------------------------------------------------------
// Ethernet header field extractor package
// Types and constants shared by the capture logic and the top level.
// ----------------------------------------------------------------------------
package ehfe_pkg;

	localparam logic [15:0] ETH_HDR_BYTES  = 16'd14;
	localparam logic [15:0] IPV6_HDR_BYTES = 16'd40;
	localparam logic [15:0] IHL_UNIT_BYTES = 16'd4;

	localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
	localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
	localparam logic [15:0] ETYPE_ARP  = 16'h0806;

	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	localparam logic [1:0] KIND_IPV4 = 2'd0;
	localparam logic [1:0] KIND_IPV6 = 2'd1;
	localparam logic [1:0] KIND_ARP  = 2'd2;

	localparam logic [15:0] POS_MAX = 16'hFFFF;

	typedef struct packed {
		logic [15:0]  pos;
		logic [15:0]  etype;
		logic [3:0]   ihl;
		logic [7:0]   proto;
		logic [47:0]  src_hw;
		logic [47:0]  dst_hw;
		logic [127:0] src_net;
		logic [127:0] dst_net;
		logic [31:0]  ports;
		logic [2:0]   ports_seen;
	} frame_state_t;

	typedef struct packed {
		logic [1:0]  packet_kind;
		logic [47:0] source_mac;
		logic [47:0] destination_mac;
		logic [15:0] frame_bytes;
		logic [63:0] source_addr_high;
		logic [63:0] source_addr_low;
		logic [63:0] dest_addr_high;
		logic [63:0] dest_addr_low;
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic        ports_valid;
	} record_t;

endpackage

// File: sv/ehfe_capture.sv
// ----------------------------------------------------------------------------
// Ethernet header field capture
// Holds the per-frame header state, folds in one byte per cycle while take is high,
// and forms the record of an IPv4, IPv6 or ARP frame when its last byte is taken.
// ----------------------------------------------------------------------------
module ehfe_capture
	import ehfe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       rec_valid,
	output record_t    rec
);

	frame_state_t st_q;
	frame_state_t nx;

	logic [15:0] pos;
	logic [3:0]  ihl_eff;
	logic [15:0] port_start;
	logic [15:0] rel6;
	logic [15:0] rel22;
	logic [15:0] rel26;
	logic [15:0] rel28;
	logic [15:0] rel30;
	logic [15:0] rel32;
	logic [15:0] rel38;
	logic [15:0] relp;
	logic        known;

	assign pos     = st_q.pos;
	assign ihl_eff = (pos == ETH_HDR_BYTES) ? data_byte[3:0] : st_q.ihl;
	assign port_start = (st_q.etype == ETYPE_IPV6) ? (ETH_HDR_BYTES + IPV6_HDR_BYTES) :
		(ETH_HDR_BYTES + IHL_UNIT_BYTES * {12'd0, ihl_eff});
	assign rel6  = pos - 16'd6;
	assign rel22 = pos - 16'd22;
	assign rel26 = pos - 16'd26;
	assign rel28 = pos - 16'd28;
	assign rel30 = pos - 16'd30;
	assign rel32 = pos - 16'd32;
	assign rel38 = pos - 16'd38;
	assign relp  = pos - port_start;

	always_comb begin
		nx = st_q;
		if (pos < 16'd6) begin
			nx.dst_hw[{3'd5 - pos[2:0], 3'b000} +: 8] =
				st_q.dst_hw[{3'd5 - pos[2:0], 3'b000} +: 8] | data_byte;
		end else if (pos < 16'd12) begin
			nx.src_hw[{3'd5 - rel6[2:0], 3'b000} +: 8] =
				st_q.src_hw[{3'd5 - rel6[2:0], 3'b000} +: 8] | data_byte;
		end else if (pos == 16'd12) begin
			nx.etype = {data_byte, 8'h00};
		end else if (pos == 16'd13) begin
			nx.etype = {st_q.etype[15:8], data_byte};
			if ({st_q.etype[15:8], data_byte} == ETYPE_ARP) begin
				nx.src_hw = '0;
				nx.dst_hw = '0;
			end
		end else if (st_q.etype == ETYPE_IPV4) begin
			if (pos == ETH_HDR_BYTES)
				nx.ihl = data_byte[3:0];
			if (pos == 16'd23)
				nx.proto = data_byte;
			if (pos >= 16'd26 && pos < 16'd30)
				nx.src_net[{2'd3 - rel26[1:0], 3'b000} +: 8] =
					st_q.src_net[{2'd3 - rel26[1:0], 3'b000} +: 8] | data_byte;
			if (pos >= 16'd30 && pos < 16'd34)
				nx.dst_net[{2'd3 - rel30[1:0], 3'b000} +: 8] =
					st_q.dst_net[{2'd3 - rel30[1:0], 3'b000} +: 8] | data_byte;
			if (pos >= port_start && pos < port_start + 16'd4) begin
				nx.ports[{2'd3 - relp[1:0], 3'b000} +: 8] =
					st_q.ports[{2'd3 - relp[1:0], 3'b000} +: 8] | data_byte;
				if (st_q.ports_seen < 3'd4)
					nx.ports_seen = st_q.ports_seen + 3'd1;
			end
		end else if (st_q.etype == ETYPE_IPV6) begin
			if (pos == 16'd20)
				nx.proto = data_byte;
			if (pos >= 16'd22 && pos < 16'd38)
				nx.src_net[{4'd15 - rel22[3:0], 3'b000} +: 8] =
					st_q.src_net[{4'd15 - rel22[3:0], 3'b000} +: 8] | data_byte;
			if (pos >= 16'd38 && pos < 16'd54)
				nx.dst_net[{4'd15 - rel38[3:0], 3'b000} +: 8] =
					st_q.dst_net[{4'd15 - rel38[3:0], 3'b000} +: 8] | data_byte;
			if (pos >= port_start && pos < port_start + 16'd4) begin
				nx.ports[{2'd3 - relp[1:0], 3'b000} +: 8] =
					st_q.ports[{2'd3 - relp[1:0], 3'b000} +: 8] | data_byte;
				if (st_q.ports_seen < 3'd4)
					nx.ports_seen = st_q.ports_seen + 3'd1;
			end
		end else if (st_q.etype == ETYPE_ARP) begin
			if (pos >= 16'd22 && pos < 16'd28) begin
				nx.src_hw[{3'd5 - rel22[2:0], 3'b000} +: 8] =
					st_q.src_hw[{3'd5 - rel22[2:0], 3'b000} +: 8] | data_byte;
			end else if (pos >= 16'd28 && pos < 16'd32) begin
				nx.src_net[{2'd3 - rel28[1:0], 3'b000} +: 8] =
					st_q.src_net[{2'd3 - rel28[1:0], 3'b000} +: 8] | data_byte;
			end else if (pos >= 16'd32 && pos < 16'd38) begin
				nx.dst_hw[{3'd5 - rel32[2:0], 3'b000} +: 8] =
					st_q.dst_hw[{3'd5 - rel32[2:0], 3'b000} +: 8] | data_byte;
			end else if (pos >= 16'd38 && pos < 16'd42) begin
				nx.dst_net[{2'd3 - rel38[1:0], 3'b000} +: 8] =
					st_q.dst_net[{2'd3 - rel38[1:0], 3'b000} +: 8] | data_byte;
			end
		end
		if (pos != POS_MAX)
			nx.pos = pos + 16'd1;
	end

	always_comb begin
		rec.packet_kind = KIND_IPV4;
		known = 1'b1;
		priority if (nx.etype == ETYPE_IPV4) begin
			rec.packet_kind = KIND_IPV4;
		end else if (nx.etype == ETYPE_IPV6) begin
			rec.packet_kind = KIND_IPV6;
		end else if (nx.etype == ETYPE_ARP) begin
			rec.packet_kind = KIND_ARP;
		end else begin
			known = 1'b0;
		end
		rec.ports_valid = (nx.proto == PROTO_TCP || nx.proto == PROTO_UDP) &&
			(nx.ports_seen == 3'd4);
		rec.source_mac       = nx.src_hw;
		rec.destination_mac  = nx.dst_hw;
		rec.frame_bytes      = nx.pos;
		rec.source_addr_high = nx.src_net[127:64];
		rec.source_addr_low  = nx.src_net[63:0];
		rec.dest_addr_high   = nx.dst_net[127:64];
		rec.dest_addr_low    = nx.dst_net[63:0];
		rec.source_port      = rec.ports_valid ? nx.ports[31:16] : 16'd0;
		rec.dest_port        = rec.ports_valid ? nx.ports[15:0] : 16'd0;
	end

	assign rec_valid = take && last_byte && known;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (take) begin
			st_q <= last_byte ? '0 : nx;
		end
	end

endmodule

// File: sv/ethernet_header_field_extractor.sv
// ----------------------------------------------------------------------------
// Ethernet header field extractor
// Takes a frame one byte per word and gives one header record per IPv4, IPv6
// or ARP frame at its last byte.
// The record is formed from the input register and held in the output register.
// Throughput: one byte per cycle while bytes arrive; the capture update is the only loop.
// A last byte waits in the input register while an earlier record is not taken.
// Reset clears the input and output valid flags and all per-frame state.
// ----------------------------------------------------------------------------
module ethernet_header_field_extractor
	import ehfe_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // data_byte
	input  logic         s_tlast,   // last_byte
	output logic         m_tvalid,
	input  logic         m_tready,
	// source_mac, destination_mac, frame_bytes, source_addr_high, source_addr_low,
	// dest_addr_high, dest_addr_low, source_port, dest_port
	output logic [399:0] m_tdata,
	output logic [7:0]   m_tuser,   // packet_kind, ports_valid, zero padding
	output logic         m_tlast
);

`include "ethernet_header_field_extractor_assert.svh"

	logic       s1_valid_q;
	logic [7:0] s1_byte_s1;
	logic       s1_last_s1;
	logic       out_free;
	logic       s1_take;
	logic       rec_valid;
	record_t    rec;
	logic       out_valid_q;
	record_t    out_rec_q;

	assign out_free = !out_valid_q || m_tready;
	assign s1_take  = s1_valid_q && (!s1_last_s1 || out_free);
	assign s_tready = !s1_valid_q || s1_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			s1_byte_s1 <= s_tdata;
			s1_last_s1 <= s_tlast;
		end
	end

	ehfe_capture u_capture (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (s1_take),
		.data_byte (s1_byte_s1),
		.last_byte (s1_last_s1),
		.rec_valid (rec_valid),
		.rec       (rec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rec_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_valid)
			out_rec_q <= rec;
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = 1'b1;
	assign m_tdata  = {out_rec_q.dest_port, out_rec_q.source_port,
		out_rec_q.dest_addr_low, out_rec_q.dest_addr_high,
		out_rec_q.source_addr_low, out_rec_q.source_addr_high,
		out_rec_q.frame_bytes, out_rec_q.destination_mac, out_rec_q.source_mac};
	assign m_tuser  = {5'd0, out_rec_q.ports_valid, out_rec_q.packet_kind};

	`EHFE_ASSERT_IMP(a_last_waits_for_output, s1_valid_q && s1_last_s1 && m_tvalid && !m_tready, !s1_take, "last byte taken while a record is stalled")
	`EHFE_ASSERT_IMP(a_arp_no_ports, m_tvalid && m_tuser[2], m_tuser[1:0] != KIND_ARP, "ports valid on an ARP record")
	`EHFE_ASSERT_IMP(a_ports_zero, m_tvalid && !m_tuser[2], m_tdata[399:368] == 32'd0, "ports not zero while invalid")
	`EHFE_ASSERT_NXT(a_record_loads, rec_valid, m_tvalid, "record not presented after load")

endmodule
